[rtl/tetm_pkg.sv]
// Shared types, widths, operation codes and helpers of the triangle edge twin matcher.
package tetm_pkg;

   localparam int SLOT_W          = 12;
   localparam int POS_W           = 32;
   localparam int CNT_W           = 13;
   localparam int BASE_W          = 12;
   localparam int OP_W            = 2;
   localparam int MAX_CORNERS_DEF = 4096;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
   } pos_type;

   typedef struct packed {
      logic              valid;
      logic [BASE_W-1:0] base;
   } link_type;

   function automatic logic [1:0] next_k(input logic [1:0] k);
      return (k == 2'd2) ? 2'd0 : k + 2'd1;
   endfunction

endpackage

[rtl/tetm_pos_mem.sv]
// Corner position memory with one write port and two registered read ports.
module tetm_pos_mem #(
   parameter int DEPTH = tetm_pkg::MAX_CORNERS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  tetm_pkg::pos_type wdata,
   input  logic              re,
   input  logic [AW-1:0]     raddr0,
   input  logic [AW-1:0]     raddr1,
   output tetm_pkg::pos_type rdata0,
   output tetm_pkg::pos_type rdata1
);
   import tetm_pkg::*;

   pos_type mem [DEPTH];
   pos_type rdata0_ff;
   pos_type rdata1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata0_ff <= mem[raddr0];
         rdata1_ff <= mem[raddr1];
      end
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

[rtl/tetm_link_mem.sv]
// Edge link memory with one write port and one registered read port.
module tetm_link_mem #(
   parameter int DEPTH = tetm_pkg::MAX_CORNERS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  tetm_pkg::link_type wdata,
   input  logic               re,
   input  logic [AW-1:0]      raddr,
   output tetm_pkg::link_type rdata
);
   import tetm_pkg::*;

   link_type mem [DEPTH];
   link_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/triangle_edge_twin_matcher.sv]
// Top level of the triangle edge twin matcher: sequencer, memories and result register.
// A write leaves the block idle; a read passes the registered link read and the RESULT state
// into the result register, and the block is back in idle as the result appears.
// A run clears all MAX_CORNERS links, one per cycle, then walks the edges: each unlinked edge
// is compared with each later edge in turn, and a match writes the links of both edges.
// A held result stalls the block once a new result is due. After reset all links are cleared.
module triangle_edge_twin_matcher #(
   parameter int MAX_CORNERS = tetm_pkg::MAX_CORNERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tetm_pkg::OP_W-1:0]     req_op,
   input  logic [tetm_pkg::SLOT_W-1:0]   req_slot,
   input  logic [tetm_pkg::POS_W-1:0]    req_pos_x,
   input  logic [tetm_pkg::POS_W-1:0]    req_pos_y,
   input  logic [tetm_pkg::POS_W-1:0]    req_pos_z,
   input  logic [tetm_pkg::CNT_W-1:0]    req_corner_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tetm_pkg::BASE_W-1:0]   rsp_neighbor_base,
   output logic                          rsp_has_neighbor,
   output logic                          rsp_run_done
);
   import tetm_pkg::*;

   localparam int AW = $clog2(MAX_CORNERS);
   localparam int CW = AW + 1;
   localparam int KW = ((CW > CNT_W) ? CW : CNT_W) + 1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CLEAR  = 9'b000000010,
      ST_TCHECK = 9'b000000100,
      ST_TTEST  = 9'b000001000,
      ST_TLOAD  = 9'b000010000,
      ST_ICMP   = 9'b000100000,
      ST_LINKT  = 9'b001000000,
      ST_LINKI  = 9'b010000000,
      ST_RESULT = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 run_ff, run_in;
   logic [KW-1:0]        cnt_ff, cnt_in;
   logic [KW-1:0]        tb_ff, tb_in, ib_ff, ib_in;
   logic [1:0]           tk_ff, tk_in, ik_ff, ik_in;
   pos_type              a_ff, a_in, b_ff, b_in;
   logic                 res_run_ff, res_run_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BASE_W-1:0]    rsp_base_ff, rsp_base_in;
   logic                 rsp_has_ff, rsp_has_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 pos_we, pos_re;
   logic [AW-1:0]        pos_waddr, pos_raddr0, pos_raddr1;
   pos_type              pos_wdata, pos_rd0, pos_rd1;
   logic                 link_we, link_re;
   logic [AW-1:0]        link_waddr, link_raddr;
   link_type             link_wdata, link_rd;

   logic                 slot_ok;
   logic [KW-1:0]        t_nb, i_sb, i_nb;
   logic [1:0]           t_nk, i_sk, i_nk;
   logic                 t_more, i_more, match;

   assign slot_ok   = {{(KW-SLOT_W){1'b0}}, req_slot} < KW'(MAX_CORNERS);
   assign pos_we    = (state_ff == ST_IDLE) && req_valid && (req_op == OP_WRITE) && slot_ok;
   assign pos_waddr = AW'(req_slot);
   assign pos_wdata = '{x: req_pos_x, y: req_pos_y, z: req_pos_z};

   assign t_nk   = next_k(tk_ff);
   assign t_nb   = (tk_ff == 2'd2) ? tb_ff + KW'(3) : tb_ff;
   assign t_more = (t_nb + KW'(3)) <= cnt_ff;
   assign i_sb   = (state_ff == ST_TLOAD) ? tb_ff : ib_ff;
   assign i_sk   = (state_ff == ST_TLOAD) ? tk_ff : ik_ff;
   assign i_nk   = next_k(i_sk);
   assign i_nb   = (i_sk == 2'd2) ? i_sb + KW'(3) : i_sb;
   assign i_more = (i_nb + KW'(3)) <= cnt_ff;
   assign match  = (a_ff == pos_rd1) && (b_ff == pos_rd0);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      tb_in        = tb_ff;
      tk_in        = tk_ff;
      ib_in        = ib_ff;
      ik_in        = ik_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_run_in   = res_run_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_base_in  = rsp_base_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_done_in  = rsp_done_ff;
      link_we      = 1'b0;
      link_waddr   = '0;
      link_wdata   = '0;
      link_re      = 1'b0;
      link_raddr   = '0;
      pos_re       = 1'b0;
      pos_raddr0   = '0;
      pos_raddr1   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_RUN) begin
                  cnt_in     = (KW'(req_corner_count) > KW'(MAX_CORNERS)) ?
                               KW'(MAX_CORNERS) : KW'(req_corner_count);
                  run_in     = 1'b1;
                  clr_in     = '0;
                  res_run_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else if (req_op == OP_READ) begin
                  link_re    = 1'b1;
                  link_raddr = AW'(req_slot);
                  rd_ok_in   = slot_ok;
                  res_run_in = 1'b0;
                  state_in   = ST_RESULT;
               end
            end
         end
         ST_CLEAR: begin
            link_we    = 1'b1;
            link_waddr = clr_ff;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_CORNERS - 1)) begin
               clr_in = '0;
               tb_in  = '0;
               tk_in  = '0;
               if (run_ff) begin
                  state_in = (cnt_ff >= KW'(3)) ? ST_TCHECK : ST_RESULT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TCHECK: begin
            link_re    = 1'b1;
            link_raddr = AW'(tb_ff + KW'(tk_ff));
            state_in   = ST_TTEST;
         end
         ST_TTEST: begin
            if (link_rd.valid) begin
               tb_in    = t_nb;
               tk_in    = t_nk;
               state_in = t_more ? ST_TCHECK : ST_RESULT;
            end else begin
               pos_re     = 1'b1;
               pos_raddr0 = AW'(tb_ff + KW'(tk_ff));
               pos_raddr1 = AW'(tb_ff + KW'(t_nk));
               state_in   = ST_TLOAD;
            end
         end
         ST_TLOAD, ST_ICMP: begin
            if (state_ff == ST_TLOAD) begin
               a_in = pos_rd0;
               b_in = pos_rd1;
            end
            if ((state_ff == ST_ICMP) && match) begin
               state_in = ST_LINKT;
            end else if (i_more) begin
               ib_in      = i_nb;
               ik_in      = i_nk;
               pos_re     = 1'b1;
               pos_raddr0 = AW'(i_nb + KW'(i_nk));
               pos_raddr1 = AW'(i_nb + KW'(next_k(i_nk)));
               state_in   = ST_ICMP;
            end else begin
               tb_in    = t_nb;
               tk_in    = t_nk;
               state_in = t_more ? ST_TCHECK : ST_RESULT;
            end
         end
         ST_LINKT: begin
            link_we    = 1'b1;
            link_waddr = AW'(tb_ff + KW'(tk_ff));
            link_wdata = '{valid: 1'b1, base: BASE_W'(ib_ff)};
            state_in   = ST_LINKI;
         end
         ST_LINKI: begin
            link_we    = 1'b1;
            link_waddr = AW'(ib_ff + KW'(ik_ff));
            link_wdata = '{valid: 1'b1, base: BASE_W'(tb_ff)};
            tb_in      = t_nb;
            tk_in      = t_nk;
            state_in   = t_more ? ST_TCHECK : ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               run_in       = 1'b0;
               if (res_run_ff) begin
                  rsp_base_in = '0;
                  rsp_has_in  = 1'b0;
                  rsp_done_in = 1'b1;
               end else begin
                  rsp_has_in  = rd_ok_ff && link_rd.valid;
                  rsp_base_in = (rd_ok_ff && link_rd.valid) ? link_rd.base : '0;
                  rsp_done_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      tb_ff       <= tb_in;
      tk_ff       <= tk_in;
      ib_ff       <= ib_in;
      ik_ff       <= ik_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      res_run_ff  <= res_run_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_base_ff <= rsp_base_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_done_ff <= rsp_done_in;
   end

   tetm_pos_mem #(.DEPTH(MAX_CORNERS), .AW(AW)) u_pos_mem (
      .clock  (clock),
      .we     (pos_we),
      .waddr  (pos_waddr),
      .wdata  (pos_wdata),
      .re     (pos_re),
      .raddr0 (pos_raddr0),
      .raddr1 (pos_raddr1),
      .rdata0 (pos_rd0),
      .rdata1 (pos_rd1)
   );

   tetm_link_mem #(.DEPTH(MAX_CORNERS), .AW(AW)) u_link_mem (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rd)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_neighbor_base = rsp_base_ff;
   assign rsp_has_neighbor  = rsp_has_ff;
   assign rsp_run_done      = rsp_done_ff;

endmodule

[rtl/tetm_checker.sv]
// Port-level checker of the triangle edge twin matcher and its bind statement.
module tetm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tetm_pkg::BASE_W-1:0] rsp_neighbor_base,
   input logic                        rsp_has_neighbor,
   input logic                        rsp_run_done
);
   import tetm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result withdrawn before its transfer.");

   a_run_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_done |-> !rsp_has_neighbor && (rsp_neighbor_base == '0))
      else $error("Run completion carries neighbour data.");

   a_no_link_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_neighbor |-> (rsp_neighbor_base == '0))
      else $error("Non-zero base without a neighbour.");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("Block ready or showing a result during the clearing pass.");

endmodule

bind triangle_edge_twin_matcher tetm_checker u_tetm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_neighbor_base (rsp_neighbor_base),
   .rsp_has_neighbor  (rsp_has_neighbor),
   .rsp_run_done      (rsp_run_done)
);
